// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/lwcc_pkg.sv
`timescale 1ns / 1ps
package lwcc_pkg;
  localparam int Ways = 16;
  localparam int WayBits = $clog2(Ways);
  localparam int CntBits = WayBits + 1;
  localparam int DataBits = 64;
  localparam int PosBits = 31;
  localparam int QDepth = 2;

  localparam logic [1:0] ReqRead = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqFlush = 2'd2;
  localparam logic [1:0] ReqBad = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StMem = 2'd1;
  localparam logic [1:0] StErr = 2'd2;

  localparam logic [0:0] RegEntries = 1'd0;
  localparam logic [0:0] RegWrAround = 1'd1;

  typedef enum logic [1:0] {
    OpErr = 2'd0,
    OpRead = 2'd1,
    OpWrite = 2'd2,
    OpFlush = 2'd3
  } op_e;

  typedef struct packed {
    op_e op;
    logic [PosBits-1:0] position;
    logic [DataBits-1:0] wr_word;
    logic [DataBits-1:0] backing_data;
    logic backing_present;
  } cmd_t;
endpackage

// File: rtl/lru_writeback_cache_controller_top.sv
`timescale 1ns / 1ps
// Fully associative 16-way LRU write-back cache controller.
// Command channel: present req_type_i, position_i, wr_word_i, backing_data_i
// and backing_present_i with start_i; the word is taken when start_i is high
// and busy_o is low. A two-entry queue holds words until the back end is free.
// Results come out on done_o for one cycle each; last_o marks the final one.
// The receiver cannot stall; every result must be taken in its cycle.
// Read and write: one result. The back end pops the word with the tag compare
// in the same cycle and updates the cache in the next; the result is on the ports
// in the cycle after that. The back end pops a new word only when idle again,
// so it finishes each word before the next; the queue takes words meanwhile.
// Flush: after the pop, a walk of the 16 age ranks, one per cycle, giving one
// result per dirty entry, most recent first, or one empty result if none is dirty.
// Registers on the APB port: 0x0 entries in use, 0x4 write-around enable.
// Write configuration only while idle. Reset empties the cache and queue.
`include "assert_macros.svh"
module lru_writeback_cache_controller_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic [1:0] req_type_i,
  input  logic [30:0] position_i,
  input  logic [63:0] wr_word_i,
  input  logic [63:0] backing_data_i,
  input  logic backing_present_i,
  output logic done_o,
  output logic [1:0] status_o,
  output logic [63:0] rd_word_o,
  output logic mem_write_valid_o,
  output logic [30:0] mem_write_position_o,
  output logic [63:0] mem_write_data_o,
  output logic last_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import lwcc_pkg::*;
  cmd_t cmd;
  logic cmd_valid, cmd_pop, q_empty, idle;
  logic [4:0] eu;
  logic wa;
  logic [1:0] cnt_q;

  assign pready = 1'b1;
  // queue full test
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_q + {1'b0, start_i && !busy_o} - {1'b0, cmd_pop};
  end
  assign busy_o = (cnt_q == 2'(QDepth));

  lwcc_regs u_regs (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .entries_used_o(eu), .wr_around_o(wa));
  lwcc_front u_front (.clk_i, .rst_ni, .start_i, .req_type_i, .position_i, .wr_word_i,
    .backing_data_i, .backing_present_i, .busy_i(busy_o), .cmd_o(cmd),
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .q_empty_o(q_empty));
  lwcc_back u_back (.clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid),
    .cmd_pop_o(cmd_pop), .idle_o(idle), .entries_used_i(eu), .wr_around_i(wa),
    .res_valid_o(done_o), .status_o, .rd_word_o, .mem_write_valid_o,
    .mem_write_position_o, .mem_write_data_o, .last_o);

  `ASSERT_IMP(a_pop_valid, clk_i, rst_ni, cmd_pop, !q_empty)
  `ASSERT_IMP(a_pop_idle, clk_i, rst_ni, cmd_pop, idle)
  `ASSERT_IMP(a_err_clean, clk_i, rst_ni, done_o && status_o == StErr, !mem_write_valid_o)
  `ASSERT_NXT(a_exec_done, clk_i, rst_ni, cmd_pop && cmd.op != OpFlush, !done_o)
endmodule

// File: rtl/lwcc_front.sv
`timescale 1ns / 1ps
module lwcc_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [1:0] req_type_i,
  input  logic [lwcc_pkg::PosBits-1:0] position_i,
  input  logic [lwcc_pkg::DataBits-1:0] wr_word_i,
  input  logic [lwcc_pkg::DataBits-1:0] backing_data_i,
  input  logic backing_present_i,
  input  logic busy_i,
  output lwcc_pkg::cmd_t cmd_o,
  output logic cmd_valid_o,
  input  logic cmd_pop_i,
  output logic q_empty_o
);
  import lwcc_pkg::*;

  cmd_t q_q [QDepth];
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QDepth):0] cnt_q;
  cmd_t c;
  logic push;

  always_comb begin
    c.position = position_i;
    c.wr_word = wr_word_i;
    c.backing_data = backing_data_i;
    c.backing_present = backing_present_i;
    case (req_type_i)
      ReqFlush: c.op = OpFlush;
      ReqRead: c.op = (position_i == '0) ? OpErr : OpRead;
      ReqWrite: c.op = (position_i == '0) ? OpErr : OpWrite;
      default: c.op = OpErr;
    endcase
  end

  assign push = start_i && !busy_i;
  assign cmd_valid_o = (cnt_q != '0);
  assign q_empty_o = (cnt_q == '0);
  assign cmd_o = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (cmd_pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(QDepth){1'b0}}, push} - {{$clog2(QDepth){1'b0}}, cmd_pop_i};
    end
  end
endmodule

// File: rtl/lwcc_back.sv
`timescale 1ns / 1ps
module lwcc_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  lwcc_pkg::cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  output logic idle_o,
  input  logic [4:0] entries_used_i,
  input  logic wr_around_i,
  output logic res_valid_o,
  output logic [1:0] status_o,
  output logic [lwcc_pkg::DataBits-1:0] rd_word_o,
  output logic mem_write_valid_o,
  output logic [lwcc_pkg::PosBits-1:0] mem_write_position_o,
  output logic [lwcc_pkg::DataBits-1:0] mem_write_data_o,
  output logic last_o
);
  import lwcc_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SExec = 2'd1;
  localparam logic [1:0] SFlush = 2'd2;

  logic [1:0] st_q, st_d;
  cmd_t cur_q;
  logic [PosBits-1:0] key_q [Ways];
  logic [DataBits-1:0] dat_q [Ways];
  logic [WayBits-1:0] age_q [Ways];
  logic [Ways-1:0] vld_q, dty_q, stl_q;
  logic [CntBits-1:0] occ_q;
  logic hit_q;
  logic [WayBits-1:0] hidx_q;
  logic [WayBits:0] fr_q;
  logic found_q;

  logic [CntBits-1:0] lim;
  logic [Ways-1:0] hv;
  logic hit;
  logic [WayBits-1:0] hidx;
  logic vic_ok, free_ok;
  logic [WayBits-1:0] vic, free;
  logic [Ways-1:0] vm;
  logic [Ways-1:0] fm;
  logic [WayBits-1:0] fidx;
  logic fany;
  logic fmore;

  always_comb begin
    if (entries_used_i == '0) lim = CntBits'(1);
    else if (entries_used_i > 5'(Ways)) lim = CntBits'(Ways);
    else lim = CntBits'(entries_used_i);
  end

  always_comb begin
    hit = 1'b0;
    hidx = '0;
    for (int i = 0; i < Ways; i++) begin
      hv[i] = vld_q[i] && (key_q[i] == cmd_i.position);
    end
    for (int i = Ways - 1; i >= 0; i--) begin
      if (hv[i]) begin
        hit = 1'b1;
        hidx = WayBits'(i);
      end
    end
  end

  // valid ranks are always 0 .. occupancy-1, so the LRU entry holds rank occupancy-1
  always_comb begin
    vic_ok = 1'b0;
    vic = '0;
    free_ok = 1'b0;
    free = '0;
    for (int i = 0; i < Ways; i++) begin
      vm[i] = vld_q[i] && (age_q[i] == WayBits'(occ_q - 1'b1));
    end
    for (int i = Ways - 1; i >= 0; i--) begin
      if (vm[i]) begin
        vic_ok = 1'b1;
        vic = WayBits'(i);
      end
    end
    for (int i = Ways - 1; i >= 0; i--) begin
      if (!vld_q[i]) begin
        free_ok = 1'b1;
        free = WayBits'(i);
      end
    end
  end

  always_comb begin
    fany = 1'b0;
    fidx = '0;
    fmore = 1'b0;
    for (int i = 0; i < Ways; i++) begin
      fm[i] = vld_q[i] && dty_q[i] && (age_q[i] == fr_q[WayBits-1:0]);
      if (vld_q[i] && dty_q[i] && (age_q[i] > fr_q[WayBits-1:0])) fmore = 1'b1;
    end
    for (int i = Ways - 1; i >= 0; i--) begin
      if (fm[i]) begin
        fany = 1'b1;
        fidx = WayBits'(i);
      end
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: if (cmd_valid_i) st_d = (cmd_i.op == OpFlush) ? SFlush : SExec;
      SExec: st_d = SIdle;
      SFlush: if (fr_q == (WayBits+1)'(Ways - 1)) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  assign cmd_pop_o = (st_q == SIdle) && cmd_valid_i;
  assign idle_o = (st_q == SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      vld_q <= '0;
      dty_q <= '0;
      stl_q <= '0;
      occ_q <= '0;
      res_valid_o <= 1'b0;
      fr_q <= '0;
      found_q <= 1'b0;
    end else begin
      st_q <= st_d;
      res_valid_o <= 1'b0;
      if (cmd_pop_o) begin
        fr_q <= '0;
        found_q <= 1'b0;
      end
      if (st_q == SFlush) begin
        fr_q <= fr_q + 1'b1;
        if (fany) found_q <= 1'b1;
        if (fany || (fr_q == (WayBits+1)'(Ways - 1) && !found_q)) begin
          res_valid_o <= 1'b1;
          status_o <= StOk;
          rd_word_o <= '0;
          mem_write_valid_o <= fany;
          mem_write_position_o <= fany ? key_q[fidx] : '0;
          mem_write_data_o <= fany ? dat_q[fidx] : '0;
          last_o <= !fmore;
        end
      end
      if (st_q == SExec) begin
        res_valid_o <= 1'b1;
        status_o <= StOk;
        rd_word_o <= '0;
        mem_write_valid_o <= 1'b0;
        mem_write_position_o <= '0;
        mem_write_data_o <= '0;
        last_o <= 1'b1;
        case (cur_q.op)
          OpErr: status_o <= StErr;
          OpRead, OpWrite: begin
            if (cur_q.op == OpWrite && wr_around_i) begin
              mem_write_valid_o <= 1'b1;
              mem_write_position_o <= cur_q.position;
              mem_write_data_o <= cur_q.wr_word;
              if (hit_q) begin
                stl_q[hidx_q] <= 1'b1;
                status_o <= StMem;
              end
            end else if (hit_q) begin
              for (int i = 0; i < Ways; i++) begin
                if (vld_q[i] && age_q[i] < age_q[hidx_q]) age_q[i] <= age_q[i] + 1'b1;
              end
              age_q[hidx_q] <= '0;
              if (cur_q.op == OpWrite) begin
                dat_q[hidx_q] <= cur_q.wr_word;
                dty_q[hidx_q] <= 1'b1;
                stl_q[hidx_q] <= 1'b0;
              end else if (!stl_q[hidx_q]) begin
                rd_word_o <= dat_q[hidx_q];
              end else if (cur_q.backing_present) begin
                dat_q[hidx_q] <= cur_q.backing_data;
                stl_q[hidx_q] <= 1'b0;
                status_o <= StMem;
                rd_word_o <= cur_q.backing_data;
              end else begin
                status_o <= StErr;
              end
            end else if (cur_q.op == OpRead && !cur_q.backing_present) begin
              status_o <= StErr;
            end else begin
              logic [WayBits-1:0] s;
              logic ev;
              ev = (occ_q >= lim) && vic_ok;
              s = ev ? vic : free;
              if (cur_q.op == OpRead) begin
                status_o <= StMem;
                rd_word_o <= cur_q.backing_data;
              end
              if (ev && dty_q[vic]) begin
                mem_write_valid_o <= 1'b1;
                mem_write_position_o <= key_q[vic];
                mem_write_data_o <= dat_q[vic];
              end
              if (ev || free_ok) begin
                for (int i = 0; i < Ways; i++) begin
                  if (vld_q[i] && !(ev && WayBits'(i) == vic)) age_q[i] <= age_q[i] + 1'b1;
                end
                key_q[s] <= cur_q.position;
                dat_q[s] <= (cur_q.op == OpWrite) ? cur_q.wr_word : cur_q.backing_data;
                vld_q[s] <= 1'b1;
                dty_q[s] <= (cur_q.op == OpWrite);
                stl_q[s] <= 1'b0;
                age_q[s] <= '0;
                if (!ev) occ_q <= occ_q + 1'b1;
              end
            end
          end
          default: status_o <= StErr;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
      hit_q <= hit;
      hidx_q <= hidx;
    end
  end
endmodule

// File: rtl/lwcc_regs.sv
`timescale 1ns / 1ps
module lwcc_regs (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [4:0] entries_used_o,
  output logic wr_around_o
);
  import lwcc_pkg::*;
  logic [0:0] idx;
  assign idx = paddr[2:2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_used_o <= 5'd16;
      wr_around_o <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (idx)
        RegEntries: entries_used_o <= pwdata[4:0];
        RegWrAround: wr_around_o <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (idx)
      RegEntries: prdata = {27'd0, entries_used_o};
      RegWrAround: prdata = {31'd0, wr_around_o};
      default: prdata = '0;
    endcase
  end
endmodule

// File: tb/sv/lru_writeback_cache_controller_checker.sv
`timescale 1ns / 1ps
module lru_writeback_cache_controller_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic [30:0] position_i,
  input  logic [63:0] wr_word_i,
  input  logic [63:0] backing_data_i,
  input  logic        backing_present_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [63:0] rd_word_i,
  input  logic        mem_write_valid_i,
  input  logic [30:0] mem_write_position_i,
  input  logic [63:0] mem_write_data_i,
  input  logic        last_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);
  import lwcc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] rdata;
    logic        wvalid;
    logic [30:0] wpos;
    logic [63:0] wdata;
    logic        last;
  } word_t;

  logic [30:0] tag_q [Ways];
  logic [63:0] line_q [Ways];
  logic        vld_q [Ways];
  logic        dirty_q [Ways];
  logic        stale_q [Ways];
  int          rank_q [Ways];
  int          occ_q;
  int          entries_used;
  logic        wr_around;
  word_t       pending_q [$];

  function automatic int find_line(logic [30:0] pos);
    for (int i = 0; i < Ways; i++) if (vld_q[i] && tag_q[i] == pos) return i;
    return -1;
  endfunction

  function automatic void make_recent(int e);
    int r;
    r = rank_q[e];
    for (int i = 0; i < Ways; i++)
      if (vld_q[i] && i != e && rank_q[i] < r) rank_q[i]++;
    rank_q[e] = 0;
  endfunction

  function automatic void fill_line(logic [30:0] pos, logic [63:0] d, logic dty,
                                    ref word_t w);
    int slot, lim;
    slot = -1;
    lim = entries_used < 1 ? 1 : (entries_used > Ways ? Ways : entries_used);
    if (occ_q >= lim) begin
      for (int i = 0; i < Ways; i++)
        if (vld_q[i] && (slot < 0 || rank_q[i] > rank_q[slot])) slot = i;
      if (slot >= 0) begin
        if (dirty_q[slot]) begin
          w.wvalid = 1'b1;
          w.wpos = tag_q[slot];
          w.wdata = line_q[slot];
        end
        vld_q[slot] = 1'b0;
        occ_q--;
      end
    end
    if (slot < 0)
      for (int i = 0; i < Ways; i++) if (!vld_q[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) return;
    for (int i = 0; i < Ways; i++) if (vld_q[i]) rank_q[i]++;
    tag_q[slot] = pos;
    line_q[slot] = d;
    vld_q[slot] = 1'b1;
    dirty_q[slot] = dty;
    stale_q[slot] = 1'b0;
    rank_q[slot] = 0;
    occ_q++;
  endfunction

  function automatic void predict_cache(logic [1:0] req, logic [30:0] pos,
                                        logic [63:0] wd, logic [63:0] bd, logic bp);
    word_t w;
    int e, n;
    w = '0;
    w.last = 1'b1;
    if (req == ReqFlush) begin
      n = 0;
      for (int r = 0; r < Ways; r++)
        for (int i = 0; i < Ways; i++)
          if (vld_q[i] && dirty_q[i] && rank_q[i] == r) begin
            w = '0;
            w.wvalid = 1'b1;
            w.wpos = tag_q[i];
            w.wdata = line_q[i];
            pending_q.push_back(w);
            n++;
          end
      if (n == 0) begin
        w = '0;
        w.last = 1'b1;
        pending_q.push_back(w);
      end else pending_q[$].last = 1'b1;
      return;
    end
    if (req == ReqBad || pos == '0) begin
      w.status = StErr;
      pending_q.push_back(w);
      return;
    end
    e = find_line(pos);
    if (req == ReqRead) begin
      if (e >= 0) begin
        make_recent(e);
        if (!stale_q[e]) w.rdata = line_q[e];
        else if (bp) begin
          line_q[e] = bd;
          stale_q[e] = 1'b0;
          w.status = StMem;
          w.rdata = bd;
        end else w.status = StErr;
      end else if (!bp) w.status = StErr;
      else begin
        fill_line(pos, bd, 1'b0, w);
        w.status = StMem;
        w.rdata = bd;
      end
    end else if (wr_around) begin
      if (e >= 0) begin
        stale_q[e] = 1'b1;
        w.status = StMem;
      end
      w.wvalid = 1'b1;
      w.wpos = pos;
      w.wdata = wd;
    end else if (e >= 0) begin
      make_recent(e);
      line_q[e] = wd;
      dirty_q[e] = 1'b1;
      stale_q[e] = 1'b0;
    end else fill_line(pos, wd, 1'b1, w);
    pending_q.push_back(w);
  endfunction

  task automatic cmp(string f, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", f, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin
    word_t w;
    if (!rst_ni) begin
      errors_o = 0;
      occ_q = 0;
      entries_used = 16;
      wr_around = 1'b0;
      pending_q.delete();
      for (int i = 0; i < Ways; i++) begin
        vld_q[i] = 0; dirty_q[i] = 0; stale_q[i] = 0; rank_q[i] = 0;
        tag_q[i] = '0; line_q[i] = '0;
      end
    end else begin
      if (done_i) begin
        if (pending_q.size() == 0) begin
          $error("unexpected word: status %0d", status_i);
          errors_o++;
        end else begin
          w = pending_q.pop_front();
          cmp("status", 64'(w.status), 64'(status_i));
          cmp("rd_word", w.rdata, rd_word_i);
          cmp("mem_write_valid", 64'(w.wvalid), 64'(mem_write_valid_i));
          cmp("mem_write_position", 64'(w.wpos), 64'(mem_write_position_i));
          cmp("mem_write_data", w.wdata, mem_write_data_i);
          cmp("last", 64'(w.last), 64'(last_i));
        end
      end
      if (start_i && !busy_i)
        predict_cache(req_type_i, position_i, wr_word_i, backing_data_i,
                      backing_present_i);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegWrAround) wr_around = pwdata[0];
        else entries_used = int'(pwdata[4:0]);
      end
    end
    pending_o = pending_q.size();
  end
endmodule

// File: tb/sv/lru_writeback_cache_controller_top_tb.sv
`timescale 1ns / 1ps
module lru_writeback_cache_controller_top_tb;
  import lwcc_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic busy_o;
  logic [1:0] req_type_i = '0;
  logic [30:0] position_i = '0;
  logic [63:0] wr_word_i = '0;
  logic [63:0] backing_data_i = '0;
  logic backing_present_i = 0;
  logic done_o;
  logic [1:0] status_o;
  logic [63:0] rd_word_o;
  logic mem_write_valid_o;
  logic [30:0] mem_write_position_o;
  logic [63:0] mem_write_data_o;
  logic last_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  bit calm;

  always #4 clk_i = ~clk_i;

  lru_writeback_cache_controller_top dut (.*);

  lru_writeback_cache_controller_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_type_i, .position_i,
    .wr_word_i, .backing_data_i, .backing_present_i, .done_i(done_o),
    .status_i(status_o), .rd_word_i(rd_word_o),
    .mem_write_valid_i(mem_write_valid_o),
    .mem_write_position_i(mem_write_position_o),
    .mem_write_data_i(mem_write_data_o), .last_i(last_o), .psel, .penable,
    .pwrite, .paddr, .pwdata, .pready, .errors_o(errors), .pending_o(pending));

  task automatic send_cmd(logic [1:0] req, logic [30:0] pos, logic [63:0] wd,
                          logic [63:0] bd, logic bp);
    while (!calm && $urandom_range(99) < 13) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    wr_word_i <= wd;
    backing_data_i <= bd;
    backing_present_i <= bp;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [0:0] idx, logic [31:0] v);
    drain();
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic logic [30:0] rnd_pos();
    case ($urandom_range(9))
      0: return 31'h7fffffff;
      1: return 31'($urandom());
      default: return 31'($urandom_range(24, 1));
    endcase
  endfunction

  function automatic logic [63:0] rnd_data();
    return {$urandom(), $urandom()};
  endfunction

  task automatic rnd_cmd();
    int k;
    logic [1:0] req;
    k = $urandom_range(99);
    req = k < 45 ? ReqRead : k < 90 ? ReqWrite : k < 96 ? ReqFlush : ReqBad;
    send_cmd(req, ($urandom_range(40) == 0) ? 31'd0 : rnd_pos(), rnd_data(),
             rnd_data(), $urandom_range(9) != 0);
  endtask

  initial begin
    calm = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    send_cmd(ReqFlush, '0, '0, '0, 1'b0);
    send_cmd(ReqRead, '0, '0, '0, 1'b1);
    send_cmd(ReqWrite, '0, '1, '0, 1'b1);
    send_cmd(ReqBad, 31'd5, '0, '0, 1'b1);
    send_cmd(ReqRead, 31'h7fffffff, '0, '1, 1'b1);
    send_cmd(ReqRead, 31'd7, '0, 64'h1234, 1'b0);
    send_cmd(ReqWrite, 31'd7, '1, '0, 1'b0);
    send_cmd(ReqWrite, 31'h7fffffff, 64'h0, '0, 1'b0);
    send_cmd(ReqRead, 31'd7, '0, '0, 1'b0);
    send_cmd(ReqFlush, '0, '0, '0, 1'b0);
    reg_write(RegWrAround, 32'd1);
    send_cmd(ReqWrite, 31'd7, 64'hdead, '0, 1'b0);
    send_cmd(ReqWrite, 31'd9, 64'hbeef, '0, 1'b0);
    send_cmd(ReqRead, 31'd7, '0, '0, 1'b0);
    send_cmd(ReqWrite, 31'd7, 64'h55, '0, 1'b0);
    send_cmd(ReqRead, 31'd7, '0, 64'haaaa, 1'b1);
    reg_write(RegWrAround, 32'd0);
    send_cmd(ReqWrite, 31'd7, 64'h77, '0, 1'b0);
    reg_write(RegEntries, 32'd1);
    send_cmd(ReqWrite, 31'd3, 64'h33, '0, 1'b0);
    send_cmd(ReqRead, 31'd4, '0, 64'h44, 1'b1);
    reg_write(RegEntries, 32'd0);
    send_cmd(ReqWrite, 31'd5, 64'h5, '0, 1'b0);
    send_cmd(ReqFlush, '0, '0, '0, 1'b0);
    reg_write(RegEntries, 32'd31);
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: reg_write(RegEntries, 32'd4);
        2: reg_write(RegWrAround, 32'd1);
        3: begin reg_write(RegWrAround, 32'd0); reg_write(RegEntries, 32'd16); end
        4: reg_write(RegEntries, 32'd2);
        5: reg_write(RegEntries, 32'd9);
        default: ;
      endcase
      calm = (ph == 3);
      repeat (33) rnd_cmd();
    end
    calm = 0;
    send_cmd(ReqFlush, '0, '0, '0, 1'b0);
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
